[hw/rtl/rdx_pkg.sv]
// Shared types, constants and helpers for the integer-to-radix-symbols block.
// No dependencies; imported by the top level, the front and the back (not by the queue).
`timescale 1ns / 1ps

package rdx_pkg;

   localparam int INPUT_W          = 32;   // width of the number port
   localparam int CHAR_W           = 8;
   localparam int TABLE_SIZE       = 32;   // symbol slots in the config table
   localparam int TABLE_BITS       = TABLE_SIZE * CHAR_W;
   localparam int CFG_W            = 64;
   localparam int CSR_INDEX_W      = 3;
   localparam int RADIX_W          = 6;    // holds 0..32
   localparam int DIGIT_W          = 5;    // digit value 0..31
   localparam int QUEUE_DEPTH      = 2;
   localparam int STEP_BITS        = 4;    // quotient bits per divider cycle
   localparam int DEF_MAX_SYMBOLS  = 32;
   localparam int DEF_NUMBER_WIDTH = 32;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYMBOL_COUNT     = 3'd0,
      CSR_SYMBOLS_LOW      = 3'd1,
      CSR_SYMBOLS_MID_LOW  = 3'd2,
      CSR_SYMBOLS_MID_HIGH = 3'd3,
      CSR_SYMBOLS_HIGH     = 3'd4
   } csr_index_type;

   // Per-transaction control handed from front to back.
   typedef struct packed {
      logic                neg;
      logic [RADIX_W-1:0]  radix;
   } rdx_ctl_type;

   function automatic logic [CHAR_W-1:0] sym_at(input logic [TABLE_BITS-1:0] tbl,
                                                input logic [DIGIT_W-1:0]    k);
      return tbl[{k, 3'b000} +: CHAR_W];
   endfunction

endpackage

[hw/rtl/integer_to_radix_symbols.sv]
// Signed integer to text in a radix given by a configurable symbol table.
// Top level: CSR registers, front check, queue and back conversion. Uses rdx_pkg.
//
// Usage:
//   Load symbol_count (index 0) and the four 64-bit symbol words (indexes 1..4)
//   through csr_we/csr_index/csr_wdata while the block is idle.
//   A number is taken when start is high and busy is low. Its text comes out
//   on rsp_character, most significant digit first, with '-' ahead of negative
//   values; rsp_valid marks each character for exactly one cycle and rsp_last
//   marks the final one. A table that is too short, repeats a symbol or holds
//   '+' or '-' produces no characters for that number.
// Timing:
//   The front checks the table one symbol per cycle, then waits for a free
//   queue slot. The back divider works out the digits one after another,
//   then emits one character per cycle, the minus sign first if there is
//   one. The two-entry queue overlaps check and conversion.
// Reset clears the CSR registers, table included (radix 0 rejects every number)
// and control state. The receiver cannot stall: each character is shown once.
`timescale 1ns / 1ps

module integer_to_radix_symbols
   import rdx_pkg::*;
#(
   parameter int MAX_SYMBOLS  = DEF_MAX_SYMBOLS,
   parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic signed [INPUT_W-1:0] req_number,
   output logic                   rsp_valid,
   output logic [CHAR_W-1:0]      rsp_character,
   output logic                   rsp_last,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   localparam int QDATA_W = $bits(rdx_ctl_type) + NUMBER_WIDTH;

   logic [RADIX_W-1:0]      symbol_count_ff;
   logic [TABLE_BITS-1:0]   table_ff;

   logic                    q_push, q_full, q_pop, q_empty;
   rdx_ctl_type             push_ctl, pop_ctl;
   logic [NUMBER_WIDTH-1:0] push_mag, pop_mag;
   logic [QDATA_W-1:0]      q_wdata, q_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_count_ff <= '0;
         table_ff        <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SYMBOL_COUNT:     symbol_count_ff <= csr_wdata[RADIX_W-1:0];
            CSR_SYMBOLS_LOW:      table_ff[0*CFG_W +: CFG_W] <= csr_wdata;
            CSR_SYMBOLS_MID_LOW:  table_ff[1*CFG_W +: CFG_W] <= csr_wdata;
            CSR_SYMBOLS_MID_HIGH: table_ff[2*CFG_W +: CFG_W] <= csr_wdata;
            CSR_SYMBOLS_HIGH:     table_ff[3*CFG_W +: CFG_W] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   rdx_front #(
      .MAX_SYMBOLS  (MAX_SYMBOLS),
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .number       (req_number),
      .symbol_count (symbol_count_ff),
      .table_bits   (table_ff),
      .push         (q_push),
      .push_ctl     (push_ctl),
      .push_mag     (push_mag),
      .full         (q_full)
   );

   assign q_wdata = {push_ctl, push_mag};
   assign pop_ctl = rdx_ctl_type'(q_rdata[QDATA_W-1:NUMBER_WIDTH]);
   assign pop_mag = q_rdata[NUMBER_WIDTH-1:0];

   rdx_queue #(
      .DATA_W (QDATA_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   rdx_back #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .empty         (q_empty),
      .pop           (q_pop),
      .pop_ctl       (pop_ctl),
      .pop_mag       (pop_mag),
      .table_bits    (table_ff),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

[hw/rtl/rdx_queue.sv]
// Small flop-based FIFO between the front (table check) and back (conversion).
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module rdx_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/rdx_front.sv]
// Front end: takes a number, splits sign and magnitude, checks the symbol
// table one symbol per cycle and queues valid transactions. Uses rdx_pkg.
`timescale 1ns / 1ps

module rdx_front
   import rdx_pkg::*;
#(
   parameter int MAX_SYMBOLS  = DEF_MAX_SYMBOLS,
   parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [INPUT_W-1:0]      number,
   input  logic [RADIX_W-1:0]      symbol_count,
   input  logic [TABLE_BITS-1:0]   table_bits,
   output logic                    push,
   output rdx_ctl_type             push_ctl,
   output logic [NUMBER_WIDTH-1:0] push_mag,
   input  logic                    full
);

   typedef enum logic [1:0] {
      F_IDLE,
      F_CHECK,
      F_PUSH
   } front_state_type;

   front_state_type         state_ff, state_in;
   logic [RADIX_W-1:0]      idx_ff, idx_in;
   logic                    neg_ff, neg_in;
   logic [NUMBER_WIDTH-1:0] mag_ff, mag_in;

   logic [RADIX_W-1:0]      limit;
   logic [RADIX_W-1:0]      len;
   logic [CHAR_W-1:0]       cur_sym;
   logic                    bad_here;
   logic [NUMBER_WIDTH-1:0] raw;

   assign raw  = number[NUMBER_WIDTH-1:0];
   assign busy = (state_ff != F_IDLE);

   // Table length: symbols before the first zero byte, within the clamped count.
   always_comb begin
      limit = (symbol_count > RADIX_W'(MAX_SYMBOLS)) ? RADIX_W'(MAX_SYMBOLS) : symbol_count;
      len   = limit;
      for (int k = TABLE_SIZE - 1; k >= 0; k--) begin
         if (RADIX_W'(k) < limit && sym_at(table_bits, DIGIT_W'(k)) == '0) begin
            len = RADIX_W'(k);
         end
      end
   end

   // Symbol under check: a sign character or a later duplicate rejects the table.
   always_comb begin
      cur_sym  = sym_at(table_bits, idx_ff[DIGIT_W-1:0]);
      bad_here = (cur_sym == CHAR_PLUS) || (cur_sym == CHAR_MINUS);
      for (int j = 0; j < TABLE_SIZE; j++) begin
         if (RADIX_W'(j) > idx_ff && RADIX_W'(j) < len &&
             sym_at(table_bits, DIGIT_W'(j)) == cur_sym) begin
            bad_here = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      push     = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               neg_in   = raw[NUMBER_WIDTH-1];
               mag_in   = raw[NUMBER_WIDTH-1] ? (~raw + 1'b1) : raw;
               idx_in   = '0;
               state_in = F_CHECK;
            end
         end
         F_CHECK: begin
            if (len < RADIX_W'(2)) begin
               state_in = F_IDLE;
            end else if (idx_ff == len) begin
               state_in = F_PUSH;
            end else if (bad_here) begin
               state_in = F_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         F_PUSH: begin
            if (!full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign push_ctl.neg   = neg_ff;
   assign push_ctl.radix = len;
   assign push_mag       = mag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff <= idx_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
   end

endmodule

[hw/rtl/rdx_back.sv]
// Back end: radix divider (STEP_BITS quotient bits per cycle), digit stack
// and character output register. Uses rdx_pkg.
`timescale 1ns / 1ps

module rdx_back
   import rdx_pkg::*;
#(
   parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    empty,
   output logic                    pop,
   input  rdx_ctl_type             pop_ctl,
   input  logic [NUMBER_WIDTH-1:0] pop_mag,
   input  logic [TABLE_BITS-1:0]   table_bits,
   output logic                    rsp_valid,
   output logic [CHAR_W-1:0]       rsp_character,
   output logic                    rsp_last
);

   localparam int STEPS  = (NUMBER_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_W  = STEPS * STEP_BITS;
   localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int IDX_W  = $clog2(NUMBER_WIDTH);
   localparam int SP_W   = $clog2(NUMBER_WIDTH + 1);

   typedef enum logic [1:0] {
      B_IDLE,
      B_DIV,
      B_SIGN,
      B_EMIT
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic [PAD_W-1:0]   div_ff, div_in;
   logic [RADIX_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [SP_W-1:0]    sp_ff, sp_in;
   logic               neg_ff, neg_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic               valid_ff, valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;
   logic [DIGIT_W-1:0] stack_ff [NUMBER_WIDTH];

   logic [PAD_W-1:0]   div_next;
   logic [RADIX_W-1:0] rem_next;
   logic               digit_push;
   logic [SP_W-1:0]    sp_top;

   // STEP_BITS restoring-division steps; remainder stays below the radix.
   always_comb begin
      logic [RADIX_W-1:0] r;
      logic [PAD_W-1:0]   d;
      r = rem_ff;
      d = div_ff;
      for (int s = 0; s < STEP_BITS; s++) begin
         r = {r[RADIX_W-2:0], d[PAD_W-1]};
         d = {d[PAD_W-2:0], 1'b0};
         if (r >= radix_ff) begin
            r    = r - radix_ff;
            d[0] = 1'b1;
         end
      end
      div_next = d;
      rem_next = r;
   end

   assign sp_top = sp_ff - 1'b1;

   always_comb begin
      state_in   = state_ff;
      div_in     = div_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      sp_in      = sp_ff;
      neg_in     = neg_ff;
      radix_in   = radix_ff;
      valid_in   = 1'b0;
      char_in    = char_ff;
      last_in    = last_ff;
      pop        = 1'b0;
      digit_push = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               div_in   = PAD_W'(pop_mag);
               rem_in   = '0;
               step_in  = '0;
               sp_in    = '0;
               neg_in   = pop_ctl.neg;
               radix_in = pop_ctl.radix;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            div_in  = div_next;
            rem_in  = rem_next;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(STEPS - 1)) begin
               digit_push = 1'b1;
               sp_in      = sp_ff + 1'b1;
               rem_in     = '0;
               step_in    = '0;
               if (div_next == '0) begin
                  state_in = neg_ff ? B_SIGN : B_EMIT;
               end
            end
         end
         B_SIGN: begin
            valid_in = 1'b1;
            char_in  = CHAR_MINUS;
            last_in  = 1'b0;
            state_in = B_EMIT;
         end
         B_EMIT: begin
            valid_in = 1'b1;
            char_in  = sym_at(table_bits, stack_ff[sp_top[IDX_W-1:0]]);
            last_in  = (sp_ff == SP_W'(1));
            sp_in    = sp_top;
            if (sp_ff == SP_W'(1)) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         sp_ff    <= sp_in;
      end
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      neg_ff   <= neg_in;
      radix_ff <= radix_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   always_ff @(posedge clock) begin
      if (digit_push) begin
         stack_ff[sp_ff[IDX_W-1:0]] <= rem_next[DIGIT_W-1:0];
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule
